// ===== hw/rtl/awbs_pkg.sv =====
// Shared types and constants for the affine warp bilinear sampler.
// No dependencies; imported by the coordinate, filter and top modules of the block.
`timescale 1ns / 1ps
`default_nettype none
package awbs_pkg;

  // Register indexes on the configuration port (word address).
  localparam logic [2:0] REG_COEF_XU    = 3'd0;
  localparam logic [2:0] REG_COEF_XV    = 3'd1;
  localparam logic [2:0] REG_COEF_XT    = 3'd2;
  localparam logic [2:0] REG_COEF_YU    = 3'd3;
  localparam logic [2:0] REG_COEF_YV    = 3'd4;
  localparam logic [2:0] REG_COEF_YT    = 3'd5;
  localparam logic [2:0] REG_SRC_WIDTH  = 3'd6;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd7;

  localparam int PADDR_W = 5;

  localparam logic [31:0] COEF_ONE  = 32'h0001_0000;
  localparam logic [8:0]  SIZE_RST  = 9'd256;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int NUM_CH = 3;

  // Channel mean in Q16 and reciprocal std in Q0.24, red first.
  localparam logic [23:0] MEAN_Q16 [NUM_CH] = '{24'd8105165, 24'd7620526, 24'd6784942};
  localparam logic [18:0] RSTD_Q24 [NUM_CH] = '{19'd287306, 19'd293719, 19'd292413};

  // Per-sample control travelling from the coordinate stage to the filter.
  typedef struct packed {
    logic       valid;
    logic [3:0] mask;   // neighbour inside source, index {dy,dx}
    logic       x_odd;  // parity of the left neighbour column
    logic       y_odd;  // parity of the top neighbour row
  } awbs_ctl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/awbs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module awbs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/awbs_coord.sv =====
// Coordinate stages: affine products, source point, neighbour bounds and
// bank addresses for the four parity banks. Depends on awbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module awbs_coord #(
  parameter int MAX_SRC_SIDE     = 256,
  parameter int CROP_SIZE        = 256,
  parameter int WEIGHT_FRAC_BITS = 8,
  parameter int HALF             = (MAX_SRC_SIDE + 1) / 2,
  parameter int AW               = (HALF * HALF > 1) ? $clog2(HALF * HALF) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        take,
  input  wire logic                        op,
  input  wire logic [7:0]                  load_x,
  input  wire logic [7:0]                  load_y,
  input  wire logic [23:0]                 pixel,
  input  wire logic [7:0]                  dest_u,
  input  wire logic [7:0]                  dest_v,
  input  wire logic [31:0]                 coef_xu,
  input  wire logic [31:0]                 coef_xv,
  input  wire logic [31:0]                 coef_xt,
  input  wire logic [31:0]                 coef_yu,
  input  wire logic [31:0]                 coef_yv,
  input  wire logic [31:0]                 coef_yt,
  input  wire logic [8:0]                  src_width,
  input  wire logic [8:0]                  src_height,
  output logic      [3:0]                  bank_we,
  output logic      [AW-1:0]               waddr,
  output logic      [23:0]                 wdata,
  output logic      [3:0][AW-1:0]          raddr,
  output awbs_pkg::awbs_ctl_t              ctl,
  output logic      [WEIGHT_FRAC_BITS-1:0] wx,
  output logic      [WEIGHT_FRAC_BITS-1:0] wy
);
  import awbs_pkg::*;

  localparam int HW = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int SW = $clog2(MAX_SRC_SIDE + 1);
  localparam int WF = WEIGHT_FRAC_BITS;

  // Stage 1 registers.
  logic               v1;
  logic               op1;
  logic               ok1;
  logic [7:0]         lx1;
  logic [7:0]         ly1;
  logic [23:0]        pix1;
  logic signed [40:0] pxu, pxv, pyu, pyv;
  logic [31:0]        xt1, yt1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= op;
      lx1  <= load_x;
      ly1  <= load_y;
      pix1 <= pixel;
      if (op == OP_LOAD) begin
        ok1 <= (32'(load_x) < MAX_SRC_SIDE) && (32'(load_y) < MAX_SRC_SIDE);
      end else begin
        ok1 <= (32'(dest_u) < CROP_SIZE) && (32'(dest_v) < CROP_SIZE);
      end
      pxu <= $signed(coef_xu) * $signed({1'b0, dest_u});
      pxv <= $signed(coef_xv) * $signed({1'b0, dest_v});
      pyu <= $signed(coef_yu) * $signed({1'b0, dest_u});
      pyv <= $signed(coef_yv) * $signed({1'b0, dest_v});
      xt1 <= coef_xt;
      yt1 <= coef_yt;
    end
  end

  // Loads write their bank from stage 1, in order with the sample reads.
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      bank_we[b] = en && v1 && (op1 == OP_LOAD) && ok1 && ({ly1[0], lx1[0]} == 2'(b));
    end
    waddr = AW'(HW'(ly1[7:1]) * HALF + HW'(lx1[7:1]));
    wdata = pix1;
  end

  logic signed [42:0] sx, sy;
  logic signed [27:0] x0, y0, x1, y1;
  logic [SW-1:0]      w_lim, h_lim;
  logic [1:0]         xin, yin;
  logic [HW-1:0]      col [2];
  logic [HW-1:0]      row [2];

  always_comb begin
    sx = 43'(pxu) + 43'(pxv) + 43'($signed(xt1));
    sy = 43'(pyu) + 43'(pyv) + 43'($signed(yt1));
    x0 = 28'(sx >>> 16);
    y0 = 28'(sy >>> 16);
    x1 = x0 + 28'sd1;
    y1 = y0 + 28'sd1;
    w_lim = (32'(src_width) > MAX_SRC_SIDE) ? SW'(MAX_SRC_SIDE) : SW'(src_width);
    h_lim = (32'(src_height) > MAX_SRC_SIDE) ? SW'(MAX_SRC_SIDE) : SW'(src_height);
    xin[0] = !x0[27] && (x0[26:0] < 27'(w_lim));
    xin[1] = !x1[27] && (x1[26:0] < 27'(w_lim));
    yin[0] = !y0[27] && (y0[26:0] < 27'(h_lim));
    yin[1] = !y1[27] && (y1[26:0] < 27'(h_lim));
    // Bank parity p holds whichever of the two neighbours has that parity.
    for (int p = 0; p < 2; p++) begin
      col[p] = (x0[0] == p[0]) ? HW'(x0[27:1]) : HW'(x1[27:1]);
      row[p] = (y0[0] == p[0]) ? HW'(y0[27:1]) : HW'(y1[27:1]);
    end
    for (int b = 0; b < 4; b++) begin
      raddr[b] = AW'(row[b / 2] * HALF + col[b % 2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= v1 && (op1 == OP_SAMPLE) && ok1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        ctl.mask[k] <= yin[k / 2] && xin[k % 2];
      end
      ctl.x_odd <= x0[0];
      ctl.y_odd <= y0[0];
      wx <= sx[15 -: WF];
      wy <= sy[15 -: WF];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/awbs_norm.sv =====
// Bilinear filter and channel normalization stages, ending in the output
// register. Depends on awbs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module awbs_norm #(
  parameter int WEIGHT_FRAC_BITS = 8
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire awbs_pkg::awbs_ctl_t         ctl,
  input  wire logic [WEIGHT_FRAC_BITS-1:0] wx,
  input  wire logic [WEIGHT_FRAC_BITS-1:0] wy,
  input  wire logic [3:0][23:0]            bank_data,
  output logic                             out_v,
  output logic signed [15:0]               red_norm,
  output logic signed [15:0]               green_norm,
  output logic signed [15:0]               blue_norm
);
  import awbs_pkg::*;

  localparam int WF    = WEIGHT_FRAC_BITS;
  localparam int WW    = 2 * WF + 2;
  localparam int ACC_W = 2 * WF + 10;
  localparam int SH    = 32 - 2 * WF;

  // Stage A: neighbour weights and pixels in {dy,dx} order.
  logic [WF:0]    wxs [2];
  logic [WF:0]    wys [2];
  logic           va;
  logic [WW-1:0]  wa  [4];
  logic [23:0]    pa  [4];

  always_comb begin
    wxs[0] = (WF+1)'(1 << WF) - (WF+1)'(wx);
    wxs[1] = (WF+1)'(wx);
    wys[0] = (WF+1)'(1 << WF) - (WF+1)'(wy);
    wys[1] = (WF+1)'(wy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= ctl.valid;
    end
  end

  // A neighbour outside the source reads an unrelated entry, so its pixel is dropped.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        wa[k] <= ctl.mask[k] ? WW'(wxs[k % 2] * wys[k / 2]) : '0;
        pa[k] <= ctl.mask[k] ? bank_data[{ctl.y_odd ^ k[1], ctl.x_odd ^ k[0]}] : '0;
      end
    end
  end

  // Stage B: weighted sums.
  logic             vb;
  logic [ACC_W-1:0] acc [NUM_CH];
  logic [ACC_W-1:0] acc_next [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc_next[c] = '0;
      for (int k = 0; k < 4; k++) begin
        acc_next[c] = acc_next[c] + ACC_W'(wa[k] * pa[k][(2 - c) * 8 +: 8]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc <= acc_next;
    end
  end

  // Stage C: mean removal and the product with 1/std, split in two halves.
  logic               vc;
  logic signed [42:0] diff [NUM_CH];
  logic signed [46:0] p_hi [NUM_CH];
  logic signed [36:0] p_lo [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      diff[c] = $signed(43'(acc[c]) << SH) - $signed(43'({MEAN_Q16[c], 16'h0}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < NUM_CH; c++) begin
        p_hi[c] <= $signed(diff[c][42:16]) * $signed({1'b0, RSTD_Q24[c]});
        p_lo[c] <= $signed({1'b0, diff[c][15:0]}) * $signed({1'b0, RSTD_Q24[c]});
      end
    end
  end

  // Stage D: recombine, round to Q12 and saturate into the output register.
  logic signed [63:0] prod [NUM_CH];
  logic signed [19:0] rnd  [NUM_CH];
  logic signed [15:0] sat  [NUM_CH];

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c] = (64'(p_hi[c]) <<< 16) + 64'(p_lo[c]) + (64'sd1 <<< 43);
      rnd[c]  = 20'(prod[c] >>> 44);
      if (rnd[c] > 20'sd32767) begin
        sat[c] = 16'sh7fff;
      end else if (rnd[c] < -20'sd32768) begin
        sat[c] = -16'sh8000;
      end else begin
        sat[c] = 16'(rnd[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_norm   <= sat[0];
      green_norm <= sat[1];
      blue_norm  <= sat[2];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/affine_warp_bilinear_sampler.sv =====
// Affine warp bilinear sampler. Load requests (op 0) write one RGB pixel into
// a source store split into four banks by row and column parity; sample
// requests (op 1) map a destination pixel through the Q16.16 inverse affine
// transform, fetch all four neighbours together from the four banks,
// filter them and emit ImageNet-normalized Q3.12 channels. The block takes
// one request per cycle while in_stall is low; a sample's result passes
// through the pipeline of multiply, bank read, weight, sum, normalize and
// output stages. A stall on the output freezes the whole pipeline. Reading a
// pixel that was never loaded gives undefined data.
// Depends on awbs_pkg, awbs_ram, awbs_coord and awbs_norm.
`timescale 1ns / 1ps
`default_nettype none
module affine_warp_bilinear_sampler #(
  parameter int MAX_SRC_SIDE     = 256,
  parameter int CROP_SIZE        = 256,
  parameter int WEIGHT_FRAC_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [awbs_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          op,
  input  wire logic [7:0]                    load_x,
  input  wire logic [7:0]                    load_y,
  input  wire logic [7:0]                    red_in,
  input  wire logic [7:0]                    green_in,
  input  wire logic [7:0]                    blue_in,
  input  wire logic [7:0]                    dest_u,
  input  wire logic [7:0]                    dest_v,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [15:0]                 red_norm,
  output logic signed [15:0]                 green_norm,
  output logic signed [15:0]                 blue_norm
);
  import awbs_pkg::*;

  localparam int HALF  = (MAX_SRC_SIDE + 1) / 2;
  localparam int DEPTH = HALF * HALF;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0] coef_xu, coef_xv, coef_xt, coef_yu, coef_yv, coef_yt;
  logic [8:0]  src_width, src_height;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_xu    <= COEF_ONE;
      coef_xv    <= '0;
      coef_xt    <= '0;
      coef_yu    <= '0;
      coef_yv    <= COEF_ONE;
      coef_yt    <= '0;
      src_width  <= SIZE_RST;
      src_height <= SIZE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_COEF_XU:    coef_xu    <= pwdata;
        REG_COEF_XV:    coef_xv    <= pwdata;
        REG_COEF_XT:    coef_xt    <= pwdata;
        REG_COEF_YU:    coef_yu    <= pwdata;
        REG_COEF_YV:    coef_yv    <= pwdata;
        REG_COEF_YT:    coef_yt    <= pwdata;
        REG_SRC_WIDTH:  src_width  <= pwdata[8:0];
        REG_SRC_HEIGHT: src_height <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_COEF_XU:    prdata = coef_xu;
      REG_COEF_XV:    prdata = coef_xv;
      REG_COEF_XT:    prdata = coef_xt;
      REG_COEF_YU:    prdata = coef_yu;
      REG_COEF_YV:    prdata = coef_yv;
      REG_COEF_YT:    prdata = coef_yt;
      REG_SRC_WIDTH:  prdata = 32'(src_width);
      REG_SRC_HEIGHT: prdata = 32'(src_height);
      default:        prdata = '0;
    endcase
  end

  // The pipeline moves whenever the output register is free or being taken.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [3:0]            bank_we;
  logic [AW-1:0]         waddr;
  logic [23:0]           wdata;
  logic [3:0][AW-1:0]    raddr;
  logic [3:0][23:0]      bank_data;
  awbs_ctl_t             ctl;
  logic [WEIGHT_FRAC_BITS-1:0] wx, wy;

  awbs_coord #(
    .MAX_SRC_SIDE     (MAX_SRC_SIDE),
    .CROP_SIZE        (CROP_SIZE),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
    .HALF             (HALF),
    .AW               (AW)
  ) u_coord (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .take       (in_valid),
    .op         (op),
    .load_x     (load_x),
    .load_y     (load_y),
    .pixel      ({red_in, green_in, blue_in}),
    .dest_u     (dest_u),
    .dest_v     (dest_v),
    .coef_xu    (coef_xu),
    .coef_xv    (coef_xv),
    .coef_xt    (coef_xt),
    .coef_yu    (coef_yu),
    .coef_yv    (coef_yv),
    .coef_yt    (coef_yt),
    .src_width  (src_width),
    .src_height (src_height),
    .bank_we    (bank_we),
    .waddr      (waddr),
    .wdata      (wdata),
    .raddr      (raddr),
    .ctl        (ctl),
    .wx         (wx),
    .wy         (wy)
  );

  for (genvar b = 0; b < 4; b++) begin : g_bank
    awbs_ram #(
      .WIDTH (24),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (waddr),
      .wdata (wdata),
      .re    (en),
      .raddr (raddr[b]),
      .rdata (bank_data[b])
    );
  end

  awbs_norm #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_norm (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .ctl        (ctl),
    .wx         (wx),
    .wy         (wy),
    .bank_data  (bank_data),
    .out_v      (out_valid),
    .red_norm   (red_norm),
    .green_norm (green_norm),
    .blue_norm  (blue_norm)
  );

endmodule
`default_nettype wire

// ===== sim/tb_affine_warp_bilinear_sampler.sv =====
// Self-checking testbench for affine_warp_bilinear_sampler: random APB settings,
// pixel loads and samples, with a bilinear/normalize predictor checking every result.
// Depends on awbs_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module tb_affine_warp_bilinear_sampler;
  import awbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 900;
  // Normalized value of a black pixel (or of no neighbour at all).
  localparam logic signed [15:0] BLACK_RED   = -16'sd8675;
  localparam logic signed [15:0] BLACK_GREEN = -16'sd8338;
  localparam logic signed [15:0] BLACK_BLUE  = -16'sd7391;

  typedef enum logic [1:0] {ROW_LOAD, ROW_SAMPLE, ROW_CFG} row_kind_t;
  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  a;      // load_x, dest_u or register index
    logic [7:0]  b;      // load_y or dest_v
    logic [31:0] val;    // packed color or register value
    logic        black;  // result is known to be the black pixel
  } dir_row_t;
  typedef struct packed {
    logic signed [15:0] r, g, b;
  } pix_norm_t;

  logic clk = 1'b0, rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall, op = OP_LOAD;
  logic [7:0] load_x = '0, load_y = '0, red_in = '0, green_in = '0, blue_in = '0;
  logic [7:0] dest_u = '0, dest_v = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [15:0] red_norm, green_norm, blue_norm;

  affine_warp_bilinear_sampler DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block: settings and source image.
  logic signed [31:0] coef [6];
  logic [8:0] width_reg, height_reg;
  logic [23:0] image [65536];
  bit written [65536];

  pix_norm_t norm_q[$];
  int unsigned progress, mismatches, results, loads, samples, cfg_writes, items;
  bit hold_long, quiet, failed;

  function automatic longint eff_side(logic [8:0] r);
    return (r > 9'd256) ? 256 : longint'(r);
  endfunction

  // Source position of neighbour {dy,dx}; returns 1 if it lies inside the source.
  function automatic bit neighbour(input logic [7:0] u, v, input int dy, dx,
                                   output int idx, output longint w);
    longint sx, sy, xx, yy, wx, wy;
    sx = longint'(coef[0]) * u + longint'(coef[1]) * v + longint'(coef[2]);
    sy = longint'(coef[3]) * u + longint'(coef[4]) * v + longint'(coef[5]);
    wx = (sx >> 8) & 255;
    wy = (sy >> 8) & 255;
    xx = (sx >>> 16) + dx;
    yy = (sy >>> 16) + dy;
    w = (dx ? wx : 256 - wx) * (dy ? wy : 256 - wy);
    idx = int'(yy * 256 + xx);
    return xx >= 0 && xx < eff_side(width_reg) && yy >= 0 && yy < eff_side(height_reg);
  endfunction

  function automatic pix_norm_t warp_normalize(logic [7:0] u, v);
    longint acc [3], w, diff, prod;
    int idx;
    logic signed [15:0] ch [3];
    acc = '{0, 0, 0};
    for (int n = 0; n < 4; n++)
      if (neighbour(u, v, n / 2, n % 2, idx, w))
        for (int c = 0; c < 3; c++)
          acc[c] += w * longint'(image[idx][23 - 8*c -: 8]);
    for (int c = 0; c < 3; c++) begin
      diff = (acc[c] <<< 16) - longint'(MEAN_Q16[c]) * 65536;
      prod = (diff * longint'(RSTD_Q24[c]) + (longint'(1) <<< 43)) >>> 44;
      ch[c] = (prod > 32767) ? 16'sh7FFF : (prod < -32768) ? 16'sh8000 : prod[15:0];
    end
    return '{ch[0], ch[1], ch[2]};
  endfunction

  // A sample may only touch loaded pixels; returns 1 and the first unloaded one.
  function automatic bit missing_pixel(logic [7:0] u, v, output int idx);
    longint w;
    for (int n = 0; n < 4; n++)
      if (neighbour(u, v, n / 2, n % 2, idx, w) && !written[idx]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int draw_wait();
    if (quiet || $urandom_range(0, 1)) return 0;
    return $urandom_range(0, 15);
  endfunction

  task automatic send(logic is_sample, logic [7:0] a, b, logic [23:0] color, bit black);
    bit stalled;
    int gap;
    op <= is_sample ? OP_SAMPLE : OP_LOAD;
    load_x <= a; load_y <= b; dest_u <= a; dest_v <= b;
    {red_in, green_in, blue_in} <= color;
    in_valid <= 1'b1;
    do begin
      @(negedge clk) stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    progress++;
    items++;
    if (is_sample) begin
      samples++;
      norm_q.push_back(black ? '{BLACK_RED, BLACK_GREEN, BLACK_BLUE} : warp_normalize(a, b));
    end else begin
      loads++;
      image[{b, a}] = color;
      written[{b, a}] = 1'b1;
    end
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    in_valid <= 1'b0;
    while (norm_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2; pwdata <= value;
    @(posedge clk) penable <= 1'b1;
    @(posedge clk) begin
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    end
    if (idx == REG_SRC_WIDTH) width_reg = value[8:0];
    else if (idx == REG_SRC_HEIGHT) height_reg = value[8:0];
    else coef[idx] = value;
    cfg_writes++;
  endtask

  function automatic logic [31:0] draw_side();
    case ($urandom_range(0, 5))
      0: return 1;
      1: return 2;
      2: return $urandom_range(3, 16);
      3: return 256;
      4: return $urandom_range(257, 511);
      default: return 0;
    endcase
  endfunction

  // Output side: random hold-off per result, one long hold when asked, checking.
  initial begin
    int k;
    bit got;
    @(negedge rst);
    forever begin
      k = hold_long ? HOLD_CYCLES : draw_wait();
      hold_long = 1'b0;
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
        out_stall <= 1'b0;
      end
      do begin
        @(negedge clk) got = out_valid && !out_stall;
        if (got) begin
          results++;
          if (norm_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %0d %0d %0d",
                                           red_norm, green_norm, blue_norm);
          end else begin
            pix_norm_t e;
            e = norm_q.pop_front();
            if (e.r !== red_norm || e.g !== green_norm || e.b !== blue_norm) begin
              mismatches++;
              if (mismatches <= 10)
                $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                         e.r, e.g, e.b, red_norm, green_norm, blue_norm);
            end
          end
        end
        @(posedge clk);
      end while (!got);
      progress++;
    end
  end

  initial begin
    int unsigned last, idle;
    @(negedge rst);
    forever begin
      last = progress;
      @(posedge clk);
      idle = (progress == last) ? idle + 1 : 0;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  dir_row_t dir_tab [22];
  initial begin
    int idx;
    logic [7:0] u, v;
    logic [31:0] vals [8];
    dir_tab = '{
      '{ROW_LOAD, 8'd0, 8'd0, 32'h000000, 1'b0},
      '{ROW_LOAD, 8'd1, 8'd0, 32'hFFFFFF, 1'b0},
      '{ROW_LOAD, 8'd0, 8'd1, 32'hFF00FF, 1'b0},
      '{ROW_LOAD, 8'd1, 8'd1, 32'h00FF00, 1'b0},
      '{ROW_SAMPLE, 8'd0, 8'd0, 32'h0, 1'b1},
      '{ROW_LOAD, 8'd255, 8'd255, 32'hFFFFFF, 1'b0},
      '{ROW_LOAD, 8'd254, 8'd255, 32'h804020, 1'b0},
      '{ROW_LOAD, 8'd255, 8'd254, 32'h01AA55, 1'b0},
      '{ROW_LOAD, 8'd254, 8'd254, 32'h7F807F, 1'b0},
      '{ROW_SAMPLE, 8'd255, 8'd255, 32'h0, 1'b0},
      '{ROW_SAMPLE, 8'd254, 8'd254, 32'h0, 1'b0},
      '{ROW_CFG, 8'(REG_SRC_WIDTH), 8'd0, 32'd0, 1'b0},
      '{ROW_SAMPLE, 8'd200, 8'd17, 32'h0, 1'b1},
      '{ROW_CFG, 8'(REG_SRC_WIDTH), 8'd0, 32'd511, 1'b0},
      '{ROW_SAMPLE, 8'd255, 8'd255, 32'h0, 1'b0},
      '{ROW_CFG, 8'(REG_COEF_XT), 8'd0, 32'hFFFF_8000, 1'b0},
      '{ROW_SAMPLE, 8'd0, 8'd0, 32'h0, 1'b0},
      '{ROW_CFG, 8'(REG_COEF_XU), 8'd0, 32'h8000_0000, 1'b0},
      '{ROW_SAMPLE, 8'd0, 8'd0, 32'h0, 1'b0},
      '{ROW_SAMPLE, 8'd1, 8'd0, 32'h0, 1'b1},
      '{ROW_CFG, 8'(REG_COEF_XU), 8'd0, 32'h7FFF_FFFF, 1'b0},
      '{ROW_SAMPLE, 8'd1, 8'd0, 32'h0, 1'b1}
    };
    coef = '{COEF_ONE, 0, 0, 0, COEF_ONE, 0};
    width_reg = SIZE_RST;
    height_reg = SIZE_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) cfg_write(dir_tab[i].a[2:0], dir_tab[i].val);
      else send(dir_tab[i].kind == ROW_SAMPLE, dir_tab[i].a, dir_tab[i].b,
                dir_tab[i].val[23:0], dir_tab[i].black);
    end

    // Random phases: every register rewritten, then mostly samples; a sample
    // that would touch an unloaded pixel becomes a load of that pixel.
    for (int phase = 0; items < RANDOM_ITEMS + 22; phase++) begin
      quiet = (phase % 3 == 2);
      if (phase % 5 == 4) begin
        foreach (vals[j]) vals[j] = $urandom();
        if (phase % 10 == 4) vals[0] = 32'h8000_0000;
        if (phase % 10 == 9) vals[4] = 32'h7FFF_FFFF;
      end else begin
        vals[0] = 32'(int'($urandom_range(0, 65535)) + 32768);
        vals[1] = 32'(int'($urandom_range(0, 32767)) - 16384);
        vals[2] = 32'(int'($urandom_range(0, 11 * 65536)) - 3 * 65536);
        vals[3] = 32'(int'($urandom_range(0, 32767)) - 16384);
        vals[4] = 32'(int'($urandom_range(0, 65535)) + 32768);
        vals[5] = 32'(int'($urandom_range(0, 11 * 65536)) - 3 * 65536);
      end
      vals[6] = draw_side();
      vals[7] = draw_side();
      for (int j = 0; j < 8; j++) cfg_write(3'(j), vals[j]);
      for (int n = 0; n < 110 && items < RANDOM_ITEMS + 22; n++) begin
        if (phase == 3 && n == 20) hold_long = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          u = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom());
          v = $urandom_range(0, 1) ? 8'($urandom_range(0, 31)) : 8'($urandom());
          send(1'b0, u, v, 24'($urandom()), 1'b0);
        end else begin
          u = $urandom_range(0, 9) < 7 ? 8'($urandom_range(0, 15)) : 8'($urandom());
          v = $urandom_range(0, 9) < 7 ? 8'($urandom_range(0, 15)) : 8'($urandom());
          if (missing_pixel(u, v, idx)) send(1'b0, idx[7:0], idx[15:8], 24'($urandom()), 1'b0);
          else send(1'b1, u, v, 24'($urandom()), 1'b0);
        end
      end
    end

    in_valid <= 1'b0;
    while (norm_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    failed = (mismatches != 0) || (norm_q.size() != 0);
    $display("Covered %0d loads and %0d samples over %0d register writes;", loads, samples,
             cfg_writes);
    $display("%0d results checked, %0d mismatches.", results, mismatches);
    if (!failed) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/awbs_pkg.sv
hw/rtl/awbs_ram.sv
hw/rtl/awbs_coord.sv
hw/rtl/awbs_norm.sv
hw/rtl/affine_warp_bilinear_sampler.sv
sim/tb_affine_warp_bilinear_sampler.sv
